>>> sv/lbp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbp_pkg
// shared types, constants and the pattern compare for the lbp code stream
// ----------------------------------------------------------------------------
package lbp_pkg;

	localparam int PIX_W    = 8;
	localparam int CFG_W_W  = 12;
	localparam int ROW_W    = 16;
	localparam int DATA_W   = 32;
	localparam int ADDR_W   = 3;
	localparam int MIN_DIM  = 3;

	localparam logic [CFG_W_W-1:0] WIDTH_RESET  = 12'd640;
	localparam logic [ROW_W-1:0]   HEIGHT_RESET = 16'd480;

	localparam logic [ADDR_W-1:0] ADDR_FRAME_WIDTH  = 3'd0;
	localparam logic [ADDR_W-1:0] ADDR_FRAME_HEIGHT = 3'd4;

	// bit positions, top-left clockwise round to left
	localparam int BIT_TL = 7;
	localparam int BIT_T  = 6;
	localparam int BIT_TR = 5;
	localparam int BIT_R  = 4;
	localparam int BIT_BR = 3;
	localparam int BIT_B  = 2;
	localparam int BIT_BL = 1;
	localparam int BIT_L  = 0;

	typedef logic [PIX_W-1:0] pix_t;

	typedef struct packed {
		logic emit;
		logic last;
	} lbp_pos_t;

	function automatic logic [7:0] lbp_code(
		input pix_t ctr,
		input pix_t tl,
		input pix_t t,
		input pix_t tr,
		input pix_t r,
		input pix_t br,
		input pix_t b,
		input pix_t bl,
		input pix_t l
	);
		logic [7:0] code;
		code         = '0;
		code[BIT_TL] = (ctr < tl);
		code[BIT_T]  = (ctr < t);
		code[BIT_TR] = (ctr < tr);
		code[BIT_R]  = (ctr < r);
		code[BIT_BR] = (ctr < br);
		code[BIT_B]  = (ctr < b);
		code[BIT_BL] = (ctr < bl);
		code[BIT_L]  = (ctr < l);
		return code;
	endfunction

endpackage
`default_nettype wire

>>> sv/lbp_code_stream.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbp_code_stream
// 3x3 eight-neighbour local binary pattern codes over a raster pixel stream
// ----------------------------------------------------------------------------
// a pixel is registered into stage s1 on accept and its code into the output
// register as s1 advances: one pixel per clock unless the output stalls; the
// line store reads the new column as it writes the last, bypassed when the
// same column is hit twice in a row. reset: counters and window cleared, width
// 640, height 480; stores not cleared, unchecked: user reads only once written
module lbp_code_stream #(
	parameter int MAX_WIDTH = 2048
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [7:0]                  pixel,
	input  wire logic                        frame_start,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [7:0]                       pattern_code,
	output logic                             frame_end,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [lbp_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [lbp_pkg::DATA_W-1:0]  pwdata,
	output logic      [lbp_pkg::DATA_W-1:0]  prdata,
	output logic                             pready
);
	import lbp_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);

	logic [CFG_W_W-1:0] frame_width_q;
	logic [ROW_W-1:0]   frame_height_q;

	logic          in_acc;
	logic          s1_adv;
	logic          out_free;
	logic          s1_valid_q;
	pix_t          pixel_s1;
	lbp_pos_t      pos_s1;
	lbp_pos_t      pos;
	logic [CW-1:0] col;
	pix_t          top;
	pix_t          mid;
	logic [7:0]    code;
	logic          out_valid_q;
	logic [7:0]    code_q;
	logic          last_q;

	// configuration port
	assign pready = 1'b1;

	always_comb begin
		case (paddr)
			ADDR_FRAME_WIDTH:  prdata = DATA_W'(frame_width_q);
			ADDR_FRAME_HEIGHT: prdata = DATA_W'(frame_height_q);
			default:           prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= WIDTH_RESET;
			frame_height_q <= HEIGHT_RESET;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr)
				ADDR_FRAME_WIDTH:  frame_width_q  <= pwdata[CFG_W_W-1:0];
				ADDR_FRAME_HEIGHT: frame_height_q <= pwdata[ROW_W-1:0];
				default: ;
			endcase
		end
	end

	// stream handshake; positions with no code pass through without the output slot
	assign out_free = !out_valid_q || out_ready;
	assign s1_adv   = s1_valid_q && (out_free || !pos_s1.emit);
	assign in_ready = !s1_valid_q || s1_adv;
	assign in_acc   = in_valid && in_ready;

	lbp_ctrl #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (in_acc),
		.frame_start  (frame_start),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.col          (col),
		.pos          (pos)
	);

	lbp_line_store #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_line_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (in_acc),
		.rd_addr  (col),
		.wr_en    (s1_adv),
		.wr_pixel (pixel_s1),
		.top      (top),
		.mid      (mid)
	);

	lbp_window u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (s1_adv),
		.pixel  (pixel_s1),
		.top    (top),
		.mid    (mid),
		.code   (code)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_acc) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pixel_s1 <= pixel;
			pos_s1   <= pos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && pos_s1.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && pos_s1.emit) begin
			code_q <= code;
			last_q <= pos_s1.last;
		end
	end

	assign out_valid    = out_valid_q;
	assign pattern_code = code_q;
	assign frame_end    = last_q;

endmodule
`default_nettype wire

>>> sv/lbp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbp_ctrl
// column and row counters; gives the line store address and the code flags
// ----------------------------------------------------------------------------
module lbp_ctrl #(
	parameter int MAX_WIDTH = 2048
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             accept,
	input  wire logic                             frame_start,
	input  wire logic [lbp_pkg::CFG_W_W-1:0]      frame_width,
	input  wire logic [lbp_pkg::ROW_W-1:0]        frame_height,
	output logic      [$clog2(MAX_WIDTH)-1:0]     col,
	output lbp_pkg::lbp_pos_t                     pos
);
	import lbp_pkg::*;

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int MWB = $clog2(MAX_WIDTH + 1);
	localparam int EW  = (MWB > CFG_W_W) ? MWB : CFG_W_W;

	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;

	logic [EW-1:0]    fw_e;
	logic [EW-1:0]    w_eff;
	logic [ROW_W-1:0] h_eff;
	logic [CW-1:0]    c0;
	logic [CW-1:0]    c1;
	logic [ROW_W-1:0] r0;
	logic [ROW_W:0]   r1;
	logic [ROW_W-1:0] r2;
	logic [ROW_W:0]   r_inc;
	logic [CW-1:0]    col_d;
	logic [ROW_W-1:0] row_d;

	always_comb begin
		fw_e = EW'(frame_width);
		if (fw_e < EW'(MIN_DIM)) begin
			w_eff = EW'(MIN_DIM);
		end else if (fw_e > EW'(MAX_WIDTH)) begin
			w_eff = EW'(MAX_WIDTH);
		end else begin
			w_eff = fw_e;
		end
		h_eff = (frame_height < ROW_W'(MIN_DIM)) ? ROW_W'(MIN_DIM) : frame_height;

		c0 = frame_start ? '0 : col_q;
		r0 = frame_start ? '0 : row_q;

		// a width cut mid-row ends the row before this pixel
		if (EW'(c0) >= w_eff) begin
			c1 = '0;
			r1 = {1'b0, r0} + 1'b1;
		end else begin
			c1 = c0;
			r1 = {1'b0, r0};
		end
		r2 = (r1 >= {1'b0, h_eff}) ? '0 : r1[ROW_W-1:0];

		pos.emit = (r2 >= ROW_W'(2)) && (c1 >= CW'(2));
		pos.last = (r2 == h_eff - 1'b1) && (EW'(c1) == w_eff - 1'b1);
		col      = c1;

		r_inc = {1'b0, r2} + 1'b1;
		if (EW'(c1) + 1'b1 >= w_eff) begin
			col_d = '0;
			row_d = (r_inc >= {1'b0, h_eff}) ? '0 : r_inc[ROW_W-1:0];
		end else begin
			col_d = c1 + 1'b1;
			row_d = r2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			col_q <= col_d;
			row_q <= row_d;
		end
	end

endmodule
`default_nettype wire

>>> sv/lbp_line_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbp_line_store
// two row memories, read on accept and written one stage later at that address
// ----------------------------------------------------------------------------
module lbp_line_store #(
	parameter int MAX_WIDTH = 2048
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         rd_en,
	input  wire logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
	input  wire logic                         wr_en,
	input  wire lbp_pkg::pix_t                wr_pixel,
	output lbp_pkg::pix_t                     top,
	output lbp_pkg::pix_t                     mid
);
	import lbp_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);

	pix_t upper_mem [MAX_WIDTH];
	pix_t lower_mem [MAX_WIDTH];

	logic [CW-1:0] addr_s1;
	pix_t          upper_rd_s1;
	pix_t          lower_rd_s1;
	logic          byp_q;
	pix_t          byp_top_s1;
	pix_t          byp_mid_s1;
	logic          hit;

	// back-to-back requests on the same column (repeated frame start)
	assign hit = rd_en && wr_en && (rd_addr == addr_s1);

	assign top = byp_q ? byp_top_s1 : upper_rd_s1;
	assign mid = byp_q ? byp_mid_s1 : lower_rd_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			upper_mem[addr_s1] <= mid;
			lower_mem[addr_s1] <= wr_pixel;
		end
		if (rd_en) begin
			upper_rd_s1 <= upper_mem[rd_addr];
			lower_rd_s1 <= lower_mem[rd_addr];
			addr_s1     <= rd_addr;
			byp_top_s1  <= mid;
			byp_mid_s1  <= wr_pixel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else if (rd_en) begin
			byp_q <= hit;
		end
	end

endmodule
`default_nettype wire

>>> sv/lbp_window.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbp_window
// two previous columns of the 3x3 window and the neighbour compare
// ----------------------------------------------------------------------------
module lbp_window (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          adv,
	input  wire lbp_pkg::pix_t pixel,
	input  wire lbp_pkg::pix_t top,
	input  wire lbp_pkg::pix_t mid,
	output logic [7:0]         code
);
	import lbp_pkg::*;

	// [0..2] column c-1 top/mid/bottom, [3..5] column c-2
	pix_t win_q [6];

	assign code = lbp_code(win_q[1], win_q[3], win_q[0], top, mid, pixel,
		win_q[2], win_q[5], win_q[4]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (adv) begin
			win_q[3] <= win_q[0];
			win_q[4] <= win_q[1];
			win_q[5] <= win_q[2];
			win_q[0] <= top;
			win_q[1] <= mid;
			win_q[2] <= pixel;
		end
	end

endmodule
`default_nettype wire

>>> tb/lbp_code_stream_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbp_code_stream_tb
// streams raster frames of many sizes through the block under random idling
// on both sides; a local 3x3 window model predicts every pattern code and the
// frame-end flag, and the monitor compares them in order as they leave
// ----------------------------------------------------------------------------
module lbp_code_stream_tb;
	import lbp_pkg::*;

	localparam int MAX_WIDTH   = 2048;
	localparam int LATENCY     = 2;
	localparam int IDLE_PCT    = 28;
	localparam int CYCLE_LIMIT = 300000;

	typedef struct packed {
		pix_t px;
		logic fs;
	} pixel_req_t;

	typedef struct packed {
		pix_t code;
		logic last;
	} lbp_result_t;

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                in_valid     = 1'b0;
	logic                in_ready;
	pix_t                pixel        = '0;
	logic                frame_start  = 1'b0;
	logic                out_valid;
	logic                out_ready    = 1'b0;
	logic [7:0]          pattern_code;
	logic                frame_end;
	logic                psel         = 1'b0;
	logic                penable      = 1'b0;
	logic                pwrite       = 1'b0;
	logic [ADDR_W-1:0]   paddr        = '0;
	logic [DATA_W-1:0]   pwdata       = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	lbp_code_stream #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.pixel       (pixel),
		.frame_start (frame_start),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pattern_code(pattern_code),
		.frame_end   (frame_end),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	always #5 clk = ~clk;

	// window model state
	logic [CFG_W_W-1:0] cfg_width;
	logic [ROW_W-1:0]   cfg_height;
	pix_t               row_back2 [MAX_WIDTH];
	pix_t               row_back1 [MAX_WIDTH];
	pix_t               col_left1 [3];	// column c-1: top, middle, bottom
	pix_t               col_left2 [3];	// column c-2: top, middle, bottom
	int                 win_col;
	int                 win_row;

	pixel_req_t  pixels_to_send [$];
	lbp_result_t codes_due [$];
	int          queued_cnt = 0;
	int          taken_cnt  = 0;
	int          fail_cnt   = 0;
	int          cycle_cnt  = 0;
	logic        req_taken  = 1'b0;
	bit          no_idle    = 1'b0;

	function automatic int eff_width();
		if (cfg_width < MIN_DIM)
			return MIN_DIM;
		if (cfg_width > MAX_WIDTH)
			return MAX_WIDTH;
		return int'(cfg_width);
	endfunction

	function automatic int eff_height();
		return (cfg_height < MIN_DIM) ? MIN_DIM : int'(cfg_height);
	endfunction

	// advance the window by one pixel; returns 1 when a code is due
	function automatic bit lbp_window_step(input pix_t px, input logic fs,
			output lbp_result_t res);
		int   w;
		int   h;
		int   c;
		int   r;
		pix_t top;
		pix_t mid;
		pix_t ctr;
		bit   emit;
		w = eff_width();
		h = eff_height();
		if (fs) begin
			win_col = 0;
			win_row = 0;
		end
		// a shrunk width ends the row before this pixel is placed
		if (win_col >= w) begin
			win_col = 0;
			win_row++;
		end
		if (win_row >= h)
			win_row = 0;
		c = win_col;
		r = win_row;
		top = row_back2[c];
		mid = row_back1[c];
		row_back2[c] = mid;
		row_back1[c] = px;
		emit = (r >= 2) && (c >= 2);
		ctr = col_left1[1];
		// top-left clockwise round to left
		res.code = {ctr < col_left2[0], ctr < col_left1[0], ctr < top, ctr < mid,
			ctr < px, ctr < col_left1[2], ctr < col_left2[2], ctr < col_left2[1]};
		res.last = (r == h - 1) && (c == w - 1);
		col_left2 = col_left1;
		col_left1[0] = top;
		col_left1[1] = mid;
		col_left1[2] = px;
		win_col = c + 1;
		if (win_col >= w) begin
			win_col = 0;
			win_row = r + 1;
			if (win_row >= h)
				win_row = 0;
		end
		return emit;
	endfunction

	// request driver
	always @(negedge clk) begin : drv_blk
		pixel_req_t nxt;
		if (arst_n) begin
			if (!in_valid || req_taken) begin
				if (pixels_to_send.size() != 0 &&
						(no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
					nxt = pixels_to_send.pop_front();
					in_valid    <= 1'b1;
					pixel       <= nxt.px;
					frame_start <= nxt.fs;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// monitor: predicts on each accepted request, checks each accepted code
	always @(posedge clk) begin : mon_blk
		lbp_result_t res;
		lbp_result_t due;
		req_taken <= arst_n && in_valid && in_ready;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				if (lbp_window_step(pixel, frame_start, res))
					codes_due = {codes_due, res};
				taken_cnt <= taken_cnt + 1;
			end
			if (out_valid && out_ready) begin
				if (codes_due.size() == 0) begin
					$error("pattern_code: none expected, got %02h", pattern_code);
					fail_cnt++;
				end else begin
					due = codes_due.pop_front();
					if (pattern_code !== due.code) begin
						$error("pattern_code: expected %02h, got %02h", due.code, pattern_code);
						fail_cnt++;
					end
					if (frame_end !== due.last) begin
						$error("frame_end: expected %0b, got %0b", due.last, frame_end);
						fail_cnt++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("lbp_code_stream_tb failed");
			$finish;
		end
	end

	// one apb transfer; a write also updates the model, a read is checked
	task automatic apb_xfer(input logic wr, input logic [ADDR_W-1:0] addr,
			input logic [DATA_W-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= wr ? data : '0;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (wr) begin
			if (addr == ADDR_FRAME_WIDTH)
				cfg_width = data[CFG_W_W-1:0];
			else
				cfg_height = data[ROW_W-1:0];
		end else if (prdata !== data) begin
			$error("prdata: expected %0d, got %0d", data, prdata);
			fail_cnt++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_frame(input int w, input int h);
		apb_xfer(1'b1, ADDR_FRAME_WIDTH, w);
		apb_xfer(1'b0, ADDR_FRAME_WIDTH, w & 'hFFF);
		apb_xfer(1'b1, ADDR_FRAME_HEIGHT, h);
		apb_xfer(1'b0, ADDR_FRAME_HEIGHT, h & 'hFFFF);
	endtask

	task automatic queue_item(input pix_t px, input logic fs);
		pixel_req_t req;
		req.px = px;
		req.fs = fs;
		pixels_to_send = {pixels_to_send, req};
		queued_cnt++;
	endtask

	// mostly whole frames, the next mark sometimes left out, plus stray marks
	task automatic queue_pixels(input int n, input bit mark_first, input int stray_pct);
		int   fsz;
		int   pos;
		logic fs;
		pix_t px;
		fsz = eff_width() * eff_height();
		pos = 0;
		for (int i = 0; i < n; i++) begin
			if (i == 0)
				fs = mark_first;
			else
				fs = (pos == 0 && $urandom_range(0, 99) < 75) ||
					($urandom_range(0, 99) < stray_pct);
			if (fs)
				pos = 0;
			// lean on equal and extreme values so the strict compare is exercised
			case ($urandom_range(0, 2))
				0: px = pix_t'($urandom_range(0, 255));
				1: px = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				default: px = pix_t'(126 + $urandom_range(0, 4));
			endcase
			queue_item(px, fs);
			pos = (pos + 1) % fsz;
		end
	endtask

	// wait for every request to go in and every code to come out
	task automatic settle();
		do
			@(negedge clk);
		while (taken_cnt != queued_cnt || codes_due.size() != 0);
		repeat (LATENCY + 2) @(negedge clk);
	endtask

	initial begin : main_blk
		logic [71:0] frame3;
		int          nw;
		int          nh;
		cfg_width  = WIDTH_RESET;
		cfg_height = HEIGHT_RESET;
		win_col    = 0;
		win_row    = 0;
		for (int i = 0; i < MAX_WIDTH; i++) begin
			row_back2[i] = '0;
			row_back1[i] = '0;
		end
		for (int i = 0; i < 3; i++) begin
			col_left1[i] = '0;
			col_left2[i] = '0;
		end
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		apb_xfer(1'b0, ADDR_FRAME_WIDTH, WIDTH_RESET);
		apb_xfer(1'b0, ADDR_FRAME_HEIGHT, HEIGHT_RESET);
		queue_pixels(8, 1'b0, 0);
		settle();

		// 3x3 frames, sizes below the minimum; row-major, top-left first
		set_frame(1, 2);
		frame3 = {8'd255, 8'd128, 8'd129, 8'd129, 8'd128, 8'd0, 8'd128, 8'd200, 8'd127};
		for (int k = 0; k < 9; k++)
			queue_item(frame3[71-8*k -: 8], k == 0);
		// next frame starts without a mark
		frame3 = {{4{8'd255}}, 8'd0, {4{8'd255}}};
		for (int k = 0; k < 9; k++)
			queue_item(frame3[71-8*k -: 8], 1'b0);
		frame3 = {{4{8'd254}}, 8'd255, {4{8'd254}}};
		for (int k = 0; k < 9; k++)
			queue_item(frame3[71-8*k -: 8], k == 0);
		settle();

		// tallest frame, then a height cut mid-frame that starts a new frame
		set_frame(3, 65535);
		queue_pixels(60, 1'b1, 0);
		settle();
		set_frame(3, 5);
		queue_pixels(40, 1'b0, 2);
		settle();

		for (int k = 0; k < 7; k++) begin
			case ($urandom_range(0, 9))
				0: nw = $urandom_range(0, 2);
				1: nw = 3;
				default: nw = $urandom_range(4, 12);
			endcase
			nh = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
			if (k == 0) begin
				nw = 3;
				nh = 3;
			end
			// a wider row needs a fresh frame so the line stores are filled first
			set_frame(nw, nh);
			queue_pixels(70, 1'b1, 3);
			settle();
			// same width mid-frame with a new height
			set_frame(nw, $urandom_range(3, 6));
			queue_pixels(15, 1'b0, 3);
			settle();
		end

		// a frame and part of the next streamed back to back
		no_idle = 1'b1;
		set_frame(16, 8);
		queue_pixels(150, 1'b1, 0);
		settle();
		no_idle = 1'b0;
		// widest row, clamped
		set_frame(4095, 3);
		queue_pixels(40, 1'b1, 0);
		settle();
		// narrower width mid-frame ends the row at once
		set_frame(0, 0);
		queue_pixels(30, 1'b0, 2);
		settle();

		if (fail_cnt == 0)
			$display("lbp_code_stream_tb passed");
		else
			$display("lbp_code_stream_tb failed");
		$finish;
	end

endmodule

>>> filelist.f
sv/lbp_pkg.sv
sv/lbp_ctrl.sv
sv/lbp_line_store.sv
sv/lbp_window.sv
sv/lbp_code_stream.sv
tb/lbp_code_stream_tb.sv
